>>> rtl/bpt_pkg.sv
// Shared types, constants and helper functions for the breakpoint table unit.
// Used by bpt_ctrl, bpt_datapath and breakpoint_table_unit; depends on nothing.
package bpt_pkg;

  // Table geometry.
  localparam int NUM_SLOTS = 8;
  localparam int ADDR_BITS = 16;
  localparam int MAX_ITEMS = 8;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int ITEM_W    = $clog2(MAX_ITEMS + 1);

  // The all-ones address marks an empty slot and an unset temporary address.
  localparam logic [ADDR_BITS-1:0] EMPTY_ADDR = '1;

  // Command codes carried in the input beat.
  typedef enum logic [2:0] {
    CMD_ADD        = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_SET_TMP    = 3'd3,
    CMD_CANCEL_TMP = 3'd4,
    CMD_PC_CHECK   = 3'd5
  } cmd_code_t;

  // Response kinds carried in the output beat.
  typedef enum logic [1:0] {
    RESP_ENTRY = 2'd0,
    RESP_EMPTY = 2'd1,
    RESP_PC    = 2'd2
  } resp_kind_t;

  // Input and output beats.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic        status;
    logic [15:0] entry_address;
    logic [3:0]  entry_count;
    logic        halt;
    logic        hit_temporary;
    logic        last;
  } out_item_t;

  // Controller state.
  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } ctrl_state_t;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR,
    OP_SET_TMP,
    OP_CANCEL_TMP,
    OP_PC_CHECK
  } dp_op_t;

  // Controller to datapath commands.
  typedef struct packed {
    dp_op_t op;
    logic   emit_list;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
    logic list_last;
  } dp_sts_t;

  // Keep only the lowest set bit of a slot vector.
  function automatic logic [NUM_SLOTS-1:0] lowest_set(input logic [NUM_SLOTS-1:0] v);
    return v & (~v + NUM_SLOTS'(1));
  endfunction

  // Number of set bits in a slot vector.
  function automatic logic [CNT_W-1:0] count_set(input logic [NUM_SLOTS-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

>>> rtl/breakpoint_table_unit.sv
// Top level of the breakpoint table unit: controller plus datapath.
// Depends on bpt_pkg, bpt_ctrl and bpt_datapath.
//
//   channel | signals                     | beat carries
//   --------+-----------------------------+-----------------------------------
//   in      | in_valid, in_stall, in_item | command and address / pc
//   out     | out_valid, out_stall, out_item | list entry, empty list or pc result
//
// A pc check or temporary-address command is taken whenever the output register can be refilled; back-to-back pc
// checks run at one per cycle while the output register drains.
// A table command first edits the table, then lists one beat per occupied slot
// (at least one beat); no input is taken until the list is out.
// Reset (rst_n low, synchronous) empties all slots and the temporary address.
// A stall on out holds the output register and, through it, stalls in.
module breakpoint_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bpt_pkg::out_item_t  out_item
);
  import bpt_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencing.
  bpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_item.cmd),
    .in_stall (in_stall),
    .dp_sts   (dp_sts),
    .dp_cmd   (dp_cmd)
  );

  // Table, compares and output register.
  bpt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> rtl/bpt_ctrl.sv
// Controller for the breakpoint table unit: decodes commands and sequences list output.
// Depends on bpt_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
module bpt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_cmd,
  output logic             in_stall,
  input  bpt_pkg::dp_sts_t dp_sts,
  output bpt_pkg::dp_cmd_t dp_cmd
);
  import bpt_pkg::*;

  ctrl_state_t state_r, state_nxt;
  dp_op_t      op_dec;
  logic        accept;
  logic        table_cmd;

  // Command decode.
  always_comb begin
    unique case (in_cmd)
      CMD_ADD:        op_dec = OP_ADD;
      CMD_REMOVE:     op_dec = OP_REMOVE;
      CMD_CLEAR:      op_dec = OP_CLEAR;
      CMD_SET_TMP:    op_dec = OP_SET_TMP;
      CMD_CANCEL_TMP: op_dec = OP_CANCEL_TMP;
      CMD_PC_CHECK:   op_dec = OP_PC_CHECK;
      default:        op_dec = OP_NONE;
    endcase
  end

  assign table_cmd = (op_dec == OP_ADD) || (op_dec == OP_REMOVE) || (op_dec == OP_CLEAR);
  assign accept    = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && table_cmd) state_nxt = ST_LIST;
      end
      ST_LIST: begin
        if (dp_sts.out_free && dp_sts.list_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: take a beat only when idle and the output register can be refilled.
  always_comb begin
    in_stall         = 1'b1;
    dp_cmd.op        = OP_NONE;
    dp_cmd.emit_list = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !dp_sts.out_free;
        if (in_valid && dp_sts.out_free) dp_cmd.op = op_dec;
      end
      ST_LIST: begin
        dp_cmd.emit_list = dp_sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/bpt_datapath.sv
// Datapath for the breakpoint table unit: slot registers, comparators, list walker
// and output register. Depends on bpt_pkg; commanded by bpt_ctrl.
module bpt_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  bpt_pkg::in_item_t in_item,
  input  bpt_pkg::dp_cmd_t  dp_cmd,
  output bpt_pkg::dp_sts_t  dp_sts,
  output logic              out_valid,
  input  logic              out_stall,
  output bpt_pkg::out_item_t out_item
);
  import bpt_pkg::*;

  logic [ADDR_BITS-1:0] slots_r [NUM_SLOTS];
  logic [ADDR_BITS-1:0] temp_r;
  logic [NUM_SLOTS-1:0] rem_r;
  logic [ITEM_W-1:0]    items_r;
  logic                 status_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [ADDR_BITS-1:0] addr_in;
  logic [NUM_SLOTS-1:0] occ, eq, zero;
  logic [NUM_SLOTS-1:0] add_sel, rem_sel, cand, list_sel;
  logic [ADDR_BITS-1:0] list_addr;
  logic [CNT_W-1:0]     occ_cnt;
  logic                 pc_valid, tmp_hit, tab_hit;
  logic                 out_free, list_last, load;
  out_item_t            load_item;

  // Per-slot compares against the incoming address.
  always_comb begin
    addr_in = in_item.address[ADDR_BITS-1:0];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      occ[i]  = slots_r[i] != EMPTY_ADDR;
      eq[i]   = slots_r[i] == addr_in;
      zero[i] = slots_r[i] == '0;
    end
  end

  // Add takes the first non-zero slot that is a duplicate or empty; remove the first match.
  assign add_sel = lowest_set(~zero & (eq | ~occ));
  assign rem_sel = lowest_set(eq);
  assign occ_cnt = count_set(occ);

  // Pc check against the temporary address and every slot.
  assign pc_valid = addr_in != EMPTY_ADDR;
  assign tmp_hit  = pc_valid && (addr_in == temp_r);
  assign tab_hit  = pc_valid && (|eq);

  // List walker: next occupied slot not yet listed.
  always_comb begin
    cand      = occ & rem_r;
    list_sel  = lowest_set(cand);
    list_addr = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      list_addr = list_addr | ({ADDR_BITS{list_sel[i]}} & slots_r[i]);
    end
    list_last = (occ == '0) || ((cand & ~list_sel) == '0)
             || (items_r == ITEM_W'(MAX_ITEMS - 1));
  end

  assign out_free = !out_valid_r || !out_stall;
  assign dp_sts.out_free  = out_free;
  assign dp_sts.list_last = list_last;

  // Output beat assembly.
  always_comb begin
    load      = 1'b0;
    load_item = '0;
    if (dp_cmd.op == OP_PC_CHECK) begin
      load                    = 1'b1;
      load_item.resp_kind     = RESP_PC;
      load_item.entry_count   = 4'(occ_cnt);
      load_item.halt          = tmp_hit || tab_hit;
      load_item.hit_temporary = tmp_hit;
      load_item.last          = 1'b1;
    end else if (dp_cmd.emit_list) begin
      load             = 1'b1;
      load_item.status = status_r;
      load_item.last   = list_last;
      if (occ == '0) begin
        load_item.resp_kind = RESP_EMPTY;
      end else begin
        load_item.resp_kind     = RESP_ENTRY;
        load_item.entry_address = 16'(list_addr);
        load_item.entry_count   = 4'(occ_cnt);
      end
    end
  end

  // Slot table and temporary address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots_r[i] <= EMPTY_ADDR;
      end
      temp_r <= EMPTY_ADDR;
    end else begin
      unique case (dp_cmd.op)
        OP_ADD: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (add_sel[i]) slots_r[i] <= addr_in;
          end
        end
        OP_REMOVE: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (rem_sel[i]) slots_r[i] <= EMPTY_ADDR;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            slots_r[i] <= EMPTY_ADDR;
          end
        end
        OP_SET_TMP:    temp_r <= addr_in;
        OP_CANCEL_TMP: temp_r <= EMPTY_ADDR;
        OP_PC_CHECK: begin
          if (tmp_hit) temp_r <= EMPTY_ADDR;
        end
        default: begin
        end
      endcase
    end
  end

  // List walker state: restarted by each table edit, advanced by each list beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      items_r  <= '0;
      status_r <= 1'b0;
    end else if ((dp_cmd.op == OP_ADD) || (dp_cmd.op == OP_REMOVE)
              || (dp_cmd.op == OP_CLEAR)) begin
      rem_r    <= '1;
      items_r  <= '0;
      status_r <= (dp_cmd.op == OP_ADD) && (add_sel == '0);
    end else if (dp_cmd.emit_list) begin
      rem_r   <= rem_r & ~list_sel;
      items_r <= items_r + ITEM_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_item_r <= load_item;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A temporary hit always leaves the temporary address unset.
  a_tmp_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == OP_PC_CHECK && tmp_hit) |=> (temp_r == EMPTY_ADDR))
    else $error("temporary address not cleared after hit");

  // A list never runs past the item limit.
  a_item_limit: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit_list |-> (items_r < ITEM_W'(MAX_ITEMS)))
    else $error("list walker ran past the item limit");

  // A listed entry is never an empty slot.
  a_entry_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.resp_kind == RESP_ENTRY)
      |-> (out_item_r.entry_address != 16'(EMPTY_ADDR)))
    else $error("empty slot listed as an entry");

endmodule

>>> tb/tb.sv
// Self-checking testbench for breakpoint_table_unit: directed and random command beats,
// checked beat by beat against a behavioural model of the slot table and step-over address.
// Depends on bpt_pkg and the breakpoint_table_unit RTL.
module tb;
  import bpt_pkg::*;

  // The two command codes that the block must ignore.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int RANDOM_BEATS     = 250;
  localparam int HOLD_AFTER_BEATS = 60;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PAUSE_AT_BEAT    = 120;
  localparam int DRAIN_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT   = 5000;

  // Scoreboard: tracks the table and step-over address, and queues the expected beats.
  class bpt_scoreboard;
    logic [ADDR_BITS-1:0] slot_addr [NUM_SLOTS];
    logic [ADDR_BITS-1:0] step_addr;
    out_item_t            expected_beats [$];
    int                   mismatches;

    function new();
      foreach (slot_addr[i]) slot_addr[i] = EMPTY_ADDR;
      step_addr  = EMPTY_ADDR;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function int occupied();
      int n;
      n = 0;
      foreach (slot_addr[i]) if (slot_addr[i] != EMPTY_ADDR) n++;
      return n;
    endfunction

    // A table command answers with the occupied slots in order, or one empty-list beat.
    function void push_list(logic status);
      out_item_t o;
      int        total;
      int        shown;
      int        k;
      total    = occupied();
      o        = '0;
      o.status = status;
      if (total == 0) begin
        o.resp_kind = RESP_EMPTY;
        o.last      = 1'b1;
        expected_beats.push_back(o);
        return;
      end
      shown         = (total < MAX_ITEMS) ? total : MAX_ITEMS;
      k             = 0;
      o.resp_kind   = RESP_ENTRY;
      o.entry_count = 4'(total);
      for (int i = 0; i < NUM_SLOTS && k < shown; i++) begin
        if (slot_addr[i] != EMPTY_ADDR) begin
          k++;
          o.entry_address = slot_addr[i];
          o.last          = (k == shown);
          expected_beats.push_back(o);
        end
      end
    endfunction

    // Apply one accepted command beat and queue the beats it should produce.
    function void note_command(in_item_t it);
      logic [ADDR_BITS-1:0] a;
      bit                   placed;
      bit                   halt;
      bit                   hit;
      out_item_t            o;
      a = it.address;
      case (it.cmd)
        CMD_ADD: begin
          // Slots holding zero are passed over; a duplicate or the first empty slot ends it.
          placed = 1'b0;
          for (int i = 0; i < NUM_SLOTS && !placed; i++) begin
            if (slot_addr[i] != '0) begin
              if (slot_addr[i] == a) begin
                placed = 1'b1;
              end else if (slot_addr[i] == EMPTY_ADDR) begin
                slot_addr[i] = a;
                placed       = 1'b1;
              end
            end
          end
          push_list(!placed);
        end
        CMD_REMOVE: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_addr[i] == a) begin
              slot_addr[i] = EMPTY_ADDR;
              break;
            end
          end
          push_list(1'b0);
        end
        CMD_CLEAR: begin
          foreach (slot_addr[i]) slot_addr[i] = EMPTY_ADDR;
          push_list(1'b0);
        end
        CMD_SET_TMP:    step_addr = a;
        CMD_CANCEL_TMP: step_addr = EMPTY_ADDR;
        CMD_PC_CHECK: begin
          // The step-over address wins over the table and is used up when it hits.
          halt = 1'b0;
          hit  = 1'b0;
          if (a != EMPTY_ADDR) begin
            if (a == step_addr) begin
              step_addr = EMPTY_ADDR;
              halt      = 1'b1;
              hit       = 1'b1;
            end else begin
              foreach (slot_addr[i]) if (slot_addr[i] == a) halt = 1'b1;
            end
          end
          o               = '0;
          o.resp_kind     = RESP_PC;
          o.entry_count   = 4'(occupied());
          o.halt          = halt;
          o.hit_temporary = hit;
          o.last          = 1'b1;
          expected_beats.push_back(o);
        end
        default: ;
      endcase
    endfunction

    function string fmt(out_item_t o);
      return $sformatf("kind %0d status %0d addr %h count %0d halt %0d hit %0d last %0d",
                       o.resp_kind, o.status, o.entry_address, o.entry_count,
                       o.halt, o.hit_temporary, o.last);
    endfunction

    // Compare one accepted result beat with the oldest expectation, field by field.
    function void check_beat(out_item_t got);
      out_item_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected result beat: %s", fmt(got)));
        return;
      end
      want = expected_beats.pop_front();
      if (got.resp_kind !== want.resp_kind || got.status !== want.status ||
          got.entry_address !== want.entry_address || got.entry_count !== want.entry_count ||
          got.halt !== want.halt || got.hit_temporary !== want.hit_temporary ||
          got.last !== want.last)
        report($sformatf("result mismatch: expected %s, got %s", fmt(want), fmt(got)));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  bpt_scoreboard  sb;
  int             beats_in;
  int             idle_cycles;
  logic [15:0]    addr_pool [8];

  breakpoint_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  wire in_fire  = (in_valid === 1'b1) && (in_stall === 1'b0);
  wire out_fire = (out_valid === 1'b1) && (out_stall === 1'b0);

  // Monitor: input beats are noted before results are checked, and a watchdog runs alongside.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        sb.note_command(in_item);
        beats_in++;
      end
      if (out_fire) sb.check_beat(out_item);
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[breakpoint_table_unit] ERROR");
        $finish;
      end
    end
  end

  // Receiver: free-running stretches, random stalls, and one long hold-off to fill the block.
  initial begin : receiver
    bit held_long;
    int r;
    held_long = 1'b0;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(9);
      if (!held_long && beats_in >= HOLD_AFTER_BEATS) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (r < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 5)) @(posedge clk);
      end else if (r == 9) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(30, 8)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(3) == 0);
        @(posedge clk);
      end
    end
  end

  // Mostly back-to-back beats, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CMD_PC_CHECK;
    if (r < 62) return CMD_ADD;
    if (r < 77) return CMD_REMOVE;
    if (r < 81) return CMD_CLEAR;
    if (r < 90) return CMD_SET_TMP;
    if (r < 95) return CMD_CANCEL_TMP;
    if (r < 97) return CMD_SPARE_A;
    return CMD_SPARE_B;
  endfunction

  // Addresses come mostly from a small pool so that duplicates, removes and hits are common.
  function automatic logic [15:0] pick_address();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'h0000;
    if (r < 12) return EMPTY_ADDR;
    if (r < 75) return addr_pool[$urandom_range(7)];
    return 16'($urandom);
  endfunction

  // Offer one beat, hold it until accepted, then leave a random gap with junk on the bus.
  task automatic offer_beat(input logic [2:0] c, input logic [15:0] a);
    int gap;
    in_valid <= 1'b1;
    in_item  <= '{cmd: c, address: a};
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_item  <= {3'($urandom), 16'($urandom)};
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    beats_in    = 0;
    idle_cycles = 0;
    sb          = new();
    foreach (addr_pool[i]) addr_pool[i] = 16'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, duplicates, zero entries and the all-ones address.
    offer_beat(CMD_PC_CHECK, 16'h0000);
    offer_beat(CMD_ADD, 16'h1234);
    offer_beat(CMD_ADD, 16'h1234);
    offer_beat(CMD_ADD, 16'h0000);
    offer_beat(CMD_ADD, 16'h0000);
    offer_beat(CMD_ADD, EMPTY_ADDR);
    offer_beat(CMD_PC_CHECK, 16'h0000);
    offer_beat(CMD_REMOVE, 16'h5555);
    offer_beat(CMD_REMOVE, 16'h0000);
    // Step-over address: hit takes precedence and clears it; cancel leaves nothing to hit.
    offer_beat(CMD_SET_TMP, 16'h1234);
    offer_beat(CMD_PC_CHECK, 16'h1234);
    offer_beat(CMD_PC_CHECK, 16'h1234);
    offer_beat(CMD_SET_TMP, 16'h00FF);
    offer_beat(CMD_CANCEL_TMP, 16'h00FF);
    offer_beat(CMD_PC_CHECK, 16'h00FF);
    // Fill every slot, then overflow the table.
    offer_beat(CMD_ADD, 16'h8000);
    offer_beat(CMD_ADD, 16'h7FFF);
    offer_beat(CMD_ADD, 16'hAAAA);
    offer_beat(CMD_ADD, 16'h5555);
    offer_beat(CMD_ADD, 16'h0001);
    offer_beat(CMD_ADD, 16'hFFFE);
    offer_beat(CMD_ADD, 16'h4321);
    // Ignored codes, an all-ones pc against an all-ones step-over address, then clear.
    offer_beat(CMD_SPARE_A, 16'hFFFF);
    offer_beat(CMD_SPARE_B, 16'h0000);
    offer_beat(CMD_SET_TMP, EMPTY_ADDR);
    offer_beat(CMD_PC_CHECK, EMPTY_ADDR);
    offer_beat(CMD_CLEAR, 16'h0000);

    // Random traffic, with one pause until every expected beat has come back.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == PAUSE_AT_BEAT) wait_drained();
      offer_beat(pick_cmd(), pick_address());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected result beats never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("[breakpoint_table_unit] OK");
    end else begin
      $display("[breakpoint_table_unit] ERROR");
    end
    $finish;
  end

endmodule
